// File: hw/rtl/esc_pkg.sv
package esc_pkg;

    localparam int unsigned DIV_STEPS = 32;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_TEMP    = 3'd0,
        REG_PRESS_A = 3'd1,
        REG_PRESS_B = 3'd2,
        REG_PRESS_C = 3'd3,
        REG_HUM_A   = 3'd4,
        REG_HUM_B   = 3'd5
    } reg_idx_t;

    // Side data that travels alongside the divider
    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
        logic        big;
        logic        zero;
    } div_sb_t;

    // Arithmetic right shift of a 32-bit word
    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

endpackage

// File: hw/rtl/esc_div.sv
module esc_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_v,
    input  logic [31:0]      num,
    input  logic [31:0]      den,
    input  esc_pkg::div_sb_t in_sb,
    output logic             out_v,
    output logic [31:0]      quo,
    output esc_pkg::div_sb_t out_sb
);
    import esc_pkg::*;

    logic [31:0] rem_c [DIV_STEPS];
    logic [31:0] n_c   [DIV_STEPS];
    logic [31:0] d_c   [DIV_STEPS];
    logic [31:0] q_c   [DIV_STEPS];
    div_sb_t     sb_c  [DIV_STEPS];
    logic        v_c   [DIV_STEPS];

    logic [31:0] rem_reg [DIV_STEPS];
    logic [31:0] n_reg   [DIV_STEPS];
    logic [31:0] d_reg   [DIV_STEPS];
    logic [31:0] q_reg   [DIV_STEPS];
    div_sb_t     sb_reg  [DIV_STEPS];
    logic        v_reg   [DIV_STEPS];

    assign rem_c[0] = '0;
    assign n_c[0]   = num;
    assign d_c[0]   = den;
    assign q_c[0]   = '0;
    assign sb_c[0]  = in_sb;
    assign v_c[0]   = in_v;

    // One quotient bit per stage, restoring
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [32:0] trial;
        logic        ge;

        if (k > 0)
        begin : g_link
            assign rem_c[k] = rem_reg[k-1];
            assign n_c[k]   = n_reg[k-1];
            assign d_c[k]   = d_reg[k-1];
            assign q_c[k]   = q_reg[k-1];
            assign sb_c[k]  = sb_reg[k-1];
            assign v_c[k]   = v_reg[k-1];
        end

        assign trial = {rem_c[k], n_c[k][31]};
        assign ge    = trial >= {1'b0, d_c[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_c[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? 32'(trial - {1'b0, d_c[k]}) : trial[31:0];
                n_reg[k]   <= {n_c[k][30:0], 1'b0};
                d_reg[k]   <= d_c[k];
                q_reg[k]   <= {q_c[k][30:0], ge};
                sb_reg[k]  <= sb_c[k];
            end
        end
    end

    assign out_v  = v_reg[DIV_STEPS-1];
    assign quo    = q_reg[DIV_STEPS-1];
    assign out_sb = sb_reg[DIV_STEPS-1];

endmodule

// File: hw/rtl/env_sensor_compensation_top.sv
// Integer compensation of raw temperature, pressure and humidity readings using packed
// calibration coefficients written over the APB port (register i at byte address 8*i,
// 64-bit data). The block takes one reading beat per cycle while not stalled and returns
// one result beat per reading, in order; the pipeline depth is set mostly by the 32-stage
// restoring divider for pressure. The whole pipeline holds while a waiting result is stalled.
// Coefficients must only be written while no reading is in flight.
module env_sensor_compensation_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [19:0] raw_temp,
    input  logic [19:0] raw_press,
    input  logic [15:0] raw_hum,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] temp_centi,
    output logic [31:0] press_pa,
    output logic [16:0] hum_q10
);
    import esc_pkg::*;

    // Configuration registers
    logic [47:0] temp_coeffs_reg, press_a_reg, press_b_reg, press_c_reg;
    logic [31:0] hum_a_reg;
    logic [39:0] hum_b_reg;
    reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            press_a_reg     <= '0;
            press_b_reg     <= '0;
            press_c_reg     <= '0;
            hum_a_reg       <= '0;
            hum_b_reg       <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (cfg_idx)
                REG_TEMP:    temp_coeffs_reg <= pwdata[47:0];
                REG_PRESS_A: press_a_reg     <= pwdata[47:0];
                REG_PRESS_B: press_b_reg     <= pwdata[47:0];
                REG_PRESS_C: press_c_reg     <= pwdata[47:0];
                REG_HUM_A:   hum_a_reg       <= pwdata[31:0];
                REG_HUM_B:   hum_b_reg       <= pwdata[39:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_TEMP:    prdata = {16'd0, temp_coeffs_reg};
            REG_PRESS_A: prdata = {16'd0, press_a_reg};
            REG_PRESS_B: prdata = {16'd0, press_b_reg};
            REG_PRESS_C: prdata = {16'd0, press_c_reg};
            REG_HUM_A:   prdata = {32'd0, hum_a_reg};
            REG_HUM_B:   prdata = {24'd0, hum_b_reg};
            default:     prdata = '0;
        endcase
    end

    // Coefficients as 32-bit words
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
    assign t1 = {16'd0, temp_coeffs_reg[15:0]};
    assign t2 = {{16{temp_coeffs_reg[31]}}, temp_coeffs_reg[31:16]};
    assign t3 = {{16{temp_coeffs_reg[47]}}, temp_coeffs_reg[47:32]};
    assign p1 = {16'd0, press_a_reg[15:0]};
    assign p2 = {{16{press_a_reg[31]}}, press_a_reg[31:16]};
    assign p3 = {{16{press_a_reg[47]}}, press_a_reg[47:32]};
    assign p4 = {{16{press_b_reg[15]}}, press_b_reg[15:0]};
    assign p5 = {{16{press_b_reg[31]}}, press_b_reg[31:16]};
    assign p6 = {{16{press_b_reg[47]}}, press_b_reg[47:32]};
    assign p7 = {{16{press_c_reg[15]}}, press_c_reg[15:0]};
    assign p8 = {{16{press_c_reg[31]}}, press_c_reg[31:16]};
    assign p9 = {{16{press_c_reg[47]}}, press_c_reg[47:32]};
    assign h1 = {24'd0, hum_a_reg[7:0]};
    assign h2 = {{16{hum_a_reg[23]}}, hum_a_reg[23:8]};
    assign h3 = {24'd0, hum_a_reg[31:24]};
    assign h4 = {{16{hum_b_reg[15]}}, hum_b_reg[15:0]};
    assign h5 = {{16{hum_b_reg[31]}}, hum_b_reg[31:16]};
    assign h6 = {{24{hum_b_reg[39]}}, hum_b_reg[39:32]};

    // Global advance: the pipe moves unless the result beat is held
    logic en;
    logic out_v_reg;
    assign en       = !out_v_reg || !out_stall;
    assign in_stall = !en;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic v9_reg, v10_reg, v11_reg, vp1_reg, vp2_reg, vp3_reg;
    logic div_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            {v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg} <= '0;
            {v9_reg, v10_reg, v11_reg, vp1_reg, vp2_reg, vp3_reg, out_v_reg} <= '0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            v7_reg    <= v6_reg;
            v8_reg    <= v7_reg;
            v9_reg    <= v8_reg;
            v10_reg   <= v9_reg;
            v11_reg   <= v10_reg;
            vp1_reg   <= div_v;
            vp2_reg   <= vp1_reg;
            vp3_reg   <= vp2_reg;
            out_v_reg <= vp3_reg;
        end
    end

    // Stage 1: temperature products
    logic [31:0] s1_ta_reg, s1_dd_reg;
    logic [19:0] s1_p_reg;
    logic [15:0] s1_h_reg;
    logic [31:0] s1_d;
    assign s1_d = {16'd0, raw_temp[19:4]} - t1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ta_reg <= ({15'd0, raw_temp[19:3]} - {t1[30:0], 1'b0}) * t2;
            s1_dd_reg <= s1_d * s1_d;
            s1_p_reg  <= raw_press;
            s1_h_reg  <= raw_hum;
        end
    end

    // Stage 2
    logic [31:0] s2_a_reg, s2_bp_reg;
    logic [19:0] s2_p_reg;
    logic [15:0] s2_h_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_a_reg  <= asr(s1_ta_reg, 11);
            s2_bp_reg <= asr(s1_dd_reg, 12) * t3;
            s2_p_reg  <= s1_p_reg;
            s2_h_reg  <= s1_h_reg;
        end
    end

    // Stage 3: fine temperature
    logic [31:0] s3_fine_reg;
    logic [19:0] s3_p_reg;
    logic [15:0] s3_h_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_fine_reg <= s2_a_reg + asr(s2_bp_reg, 14);
            s3_p_reg    <= s2_p_reg;
            s3_h_reg    <= s2_h_reg;
        end
    end

    // Stage 4: first products of pressure and humidity
    logic [31:0] s4_tm_reg, s4_qq_reg, s4_ap5_reg, s4_p2a_reg;
    logic [31:0] s4_dh6_reg, s4_dh3_reg, s4_h5d_reg;
    logic [19:0] s4_p_reg;
    logic [15:0] s4_h_reg;
    logic [31:0] s4_pa, s4_q, s4_hd;
    assign s4_pa = asr(s3_fine_reg, 1) - 32'd64000;
    assign s4_q  = asr(s4_pa, 2);
    assign s4_hd = s3_fine_reg - 32'd76800;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_tm_reg  <= s3_fine_reg * 32'd5 + 32'd128;
            s4_qq_reg  <= s4_q * s4_q;
            s4_ap5_reg <= s4_pa * p5;
            s4_p2a_reg <= p2 * s4_pa;
            s4_dh6_reg <= s4_hd * h6;
            s4_dh3_reg <= s4_hd * h3;
            s4_h5d_reg <= h5 * s4_hd;
            s4_p_reg   <= s3_p_reg;
            s4_h_reg   <= s3_h_reg;
        end
    end

    // Stage 5
    logic [31:0] s5_temp_reg, s5_b1_reg, s5_p3q_reg, s5_ap5_reg, s5_p2a_reg;
    logic [31:0] s5_ha_reg, s5_hb1_reg;
    logic [19:0] s5_p_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_temp_reg <= asr(s4_tm_reg, 8);
            s5_b1_reg   <= asr(s4_qq_reg, 11) * p6;
            s5_p3q_reg  <= p3 * asr(s4_qq_reg, 13);
            s5_ap5_reg  <= s4_ap5_reg;
            s5_p2a_reg  <= s4_p2a_reg;
            s5_ha_reg   <= asr((({2'd0, s4_h_reg, 14'd0} - {h4[11:0], 20'd0}) - s4_h5d_reg)
                               + 32'd16384, 15);
            s5_hb1_reg  <= asr(s4_dh6_reg, 10) * (asr(s4_dh3_reg, 11) + 32'd32768);
            s5_p_reg    <= s4_p_reg;
        end
    end

    // Stage 6
    logic [31:0] s6_temp_reg, s6_b2_reg, s6_a2_reg, s6_ha_reg, s6_hbm_reg;
    logic [19:0] s6_p_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_temp_reg <= s5_temp_reg;
            s6_b2_reg   <= asr(s5_b1_reg + {s5_ap5_reg[30:0], 1'b0}, 2) + {p4[15:0], 16'd0};
            s6_a2_reg   <= asr(asr(s5_p3q_reg, 3) + asr(s5_p2a_reg, 1), 18);
            s6_ha_reg   <= s5_ha_reg;
            s6_hbm_reg  <= (asr(s5_hb1_reg, 10) + 32'd2097152) * h2;
            s6_p_reg    <= s5_p_reg;
        end
    end

    // Stage 7: divisor product and pressure numerator
    logic [31:0] s7_temp_reg, s7_a3m_reg, s7_pn_reg, s7_ha_reg, s7_hb2_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_temp_reg <= s6_temp_reg;
            s7_a3m_reg  <= (32'd32768 + s6_a2_reg) * p1;
            s7_pn_reg   <= ((32'd1048576 - {12'd0, s6_p_reg}) - asr(s6_b2_reg, 12)) * 32'd3125;
            s7_ha_reg   <= s6_ha_reg;
            s7_hb2_reg  <= asr(s6_hbm_reg + 32'd8192, 14);
        end
    end

    // Stage 8: divider operands, humidity product
    logic [31:0] s8_temp_reg, s8_num_reg, s8_den_reg, s8_hd_reg;
    logic        s8_big_reg, s8_zero_reg;
    logic [31:0] s8_den;
    assign s8_den = asr(s7_a3m_reg, 15);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_temp_reg <= s7_temp_reg;
            s8_big_reg  <= s7_pn_reg[31];
            s8_num_reg  <= s7_pn_reg[31] ? s7_pn_reg : {s7_pn_reg[30:0], 1'b0};
            s8_den_reg  <= s8_den;
            s8_zero_reg <= (s8_den == '0);
            s8_hd_reg   <= s7_ha_reg * s7_hb2_reg;
        end
    end

    // Stages 9 to 11: humidity correction, divider operands wait
    logic [31:0] s9_temp_reg, s9_num_reg, s9_den_reg, s9_hd_reg, s9_hqq_reg;
    logic        s9_big_reg, s9_zero_reg;
    logic [31:0] s9_hq;
    assign s9_hq = asr(s8_hd_reg, 15);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_temp_reg <= s8_temp_reg;
            s9_num_reg  <= s8_num_reg;
            s9_den_reg  <= s8_den_reg;
            s9_big_reg  <= s8_big_reg;
            s9_zero_reg <= s8_zero_reg;
            s9_hd_reg   <= s8_hd_reg;
            s9_hqq_reg  <= s9_hq * s9_hq;
        end
    end

    logic [31:0] s10_temp_reg, s10_num_reg, s10_den_reg, s10_hd_reg, s10_hx_reg;
    logic        s10_big_reg, s10_zero_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_temp_reg <= s9_temp_reg;
            s10_num_reg  <= s9_num_reg;
            s10_den_reg  <= s9_den_reg;
            s10_big_reg  <= s9_big_reg;
            s10_zero_reg <= s9_zero_reg;
            s10_hd_reg   <= s9_hd_reg;
            s10_hx_reg   <= asr(s9_hqq_reg, 7) * h1;
        end
    end

    logic [31:0] s11_num_reg, s11_den_reg;
    div_sb_t     s11_sb_reg;
    logic [31:0] s11_hd;
    logic [31:0] s11_hc;
    assign s11_hd = s10_hd_reg - asr(s10_hx_reg, 4);

    // Clamp to 0 .. 419430400
    always_comb
    begin
        if (s11_hd[31])
        begin
            s11_hc = '0;
        end
        else if (s11_hd > 32'd419430400)
        begin
            s11_hc = 32'd419430400;
        end
        else
        begin
            s11_hc = s11_hd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s11_num_reg     <= s10_num_reg;
            s11_den_reg     <= s10_den_reg;
            s11_sb_reg.temp <= s10_temp_reg;
            s11_sb_reg.hum  <= s11_hc[28:12];
            s11_sb_reg.big  <= s10_big_reg;
            s11_sb_reg.zero <= s10_zero_reg;
        end
    end

    // Pressure division
    logic [31:0] div_quo;
    div_sb_t     div_sb;

    esc_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_v   (v11_reg),
        .num    (s11_num_reg),
        .den    (s11_den_reg),
        .in_sb  (s11_sb_reg),
        .out_v  (div_v),
        .quo    (div_quo),
        .out_sb (div_sb)
    );

    // Pressure refinement
    logic [31:0] sp1_pq_reg, sp1_temp_reg;
    logic [16:0] sp1_hum_reg;
    logic        sp1_zero_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp1_pq_reg   <= div_sb.big ? {div_quo[30:0], 1'b0} : div_quo;
            sp1_temp_reg <= div_sb.temp;
            sp1_hum_reg  <= div_sb.hum;
            sp1_zero_reg <= div_sb.zero;
        end
    end

    logic [31:0] sp2_pq_reg, sp2_temp_reg, sp2_qq_reg, sp2_pb_reg;
    logic [16:0] sp2_hum_reg;
    logic        sp2_zero_reg;
    logic [31:0] sp2_q;
    assign sp2_q = {3'd0, sp1_pq_reg[31:3]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp2_pq_reg   <= sp1_pq_reg;
            sp2_temp_reg <= sp1_temp_reg;
            sp2_hum_reg  <= sp1_hum_reg;
            sp2_zero_reg <= sp1_zero_reg;
            sp2_qq_reg   <= sp2_q * sp2_q;
            sp2_pb_reg   <= {2'd0, sp1_pq_reg[31:2]} * p8;
        end
    end

    logic [31:0] sp3_pq_reg, sp3_temp_reg, sp3_pm_reg, sp3_b_reg;
    logic [16:0] sp3_hum_reg;
    logic        sp3_zero_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp3_pq_reg   <= sp2_pq_reg;
            sp3_temp_reg <= sp2_temp_reg;
            sp3_hum_reg  <= sp2_hum_reg;
            sp3_zero_reg <= sp2_zero_reg;
            sp3_pm_reg   <= p9 * {13'd0, sp2_qq_reg[31:13]};
            sp3_b_reg    <= asr(sp2_pb_reg, 13);
        end
    end

    // Output register
    logic [31:0] temp_reg, press_reg;
    logic [16:0] hum_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp_reg  <= sp3_temp_reg;
            hum_reg   <= sp3_hum_reg;
            press_reg <= sp3_zero_reg ? '0 :
                         sp3_pq_reg + asr(asr(sp3_pm_reg, 12) + sp3_b_reg + p7, 4);
        end
    end

    assign out_valid  = out_v_reg;
    assign temp_centi = temp_reg;
    assign press_pa   = press_reg;
    assign hum_q10    = hum_reg;

`ifndef NO_ASSERTIONS
    // Input is held back only by a waiting result beat
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_v_reg && out_stall))
        else $error("input stalled without a held result");

    // Humidity never leaves its clamped range
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> (hum_reg <= 17'd102400))
        else $error("humidity out of range");

    // An accepted beat enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted beat lost at entry");

    // Zero divisor gives zero pressure
    a_zero_press: assert property (@(posedge clk) disable iff (!rst_n)
        (vp3_reg && sp3_zero_reg && en) |=> (press_reg == '0))
        else $error("zero divisor gave non-zero pressure");
`endif

endmodule

// File: bench/env_sensor_compensation_top_tb.sv
module env_sensor_compensation_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import esc_pkg::*;

    localparam int LATENCY     = 47;
    localparam int WATCH_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] temp_centi;
    logic [31:0] press_pa;
    logic [16:0] hum_q10;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] press;
        logic [16:0] hum;
    } reading_t;

    // Local copy of the calibration registers
    logic [47:0] cal_temp, cal_pa, cal_pb, cal_pc;
    logic [31:0] cal_ha;
    logic [39:0] cal_hb;

    reading_t compensated_q[$];
    int       errors;
    int       idle_cycles;
    int       send_idle_pct;
    int       recv_idle_pct;

    env_sensor_compensation_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .raw_temp(raw_temp), .raw_press(raw_press), .raw_hum(raw_hum),
        .out_valid(out_valid), .out_stall(out_stall),
        .temp_centi(temp_centi), .press_pa(press_pa), .hum_q10(hum_q10)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] sra(logic [31:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] sx(logic [47:0] r, int lo, int bits);
        logic [31:0] v;
        v = 32'((r >> lo) & ((48'd1 << bits) - 48'd1));
        if (v[bits-1])
            v = v | ~((32'd1 << bits) - 32'd1);
        return v;
    endfunction

    // Compensation arithmetic on 32-bit wrapping words
    function automatic reading_t compensate(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
        reading_t    r;
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        logic [31:0] a, b, d, fine, pq, q, hv;
        t1 = 32'(cal_temp[15:0]);
        t2 = sx(cal_temp, 16, 16);
        t3 = sx(cal_temp, 32, 16);
        p1 = 32'(cal_pa[15:0]);
        p2 = sx(cal_pa, 16, 16);
        p3 = sx(cal_pa, 32, 16);
        p4 = sx(cal_pb, 0, 16);
        p5 = sx(cal_pb, 16, 16);
        p6 = sx(cal_pb, 32, 16);
        p7 = sx(cal_pc, 0, 16);
        p8 = sx(cal_pc, 16, 16);
        p9 = sx(cal_pc, 32, 16);
        h1 = 32'(cal_ha[7:0]);
        h2 = sx({16'd0, cal_ha}, 8, 16);
        h3 = 32'(cal_ha[31:24]);
        h4 = sx({8'd0, cal_hb}, 0, 16);
        h5 = sx({8'd0, cal_hb}, 16, 16);
        h6 = sx({8'd0, cal_hb}, 32, 8);

        // temperature and fine temperature
        a = sra(((32'(rt) >> 3) - (t1 << 1)) * t2, 11);
        d = (32'(rt) >> 4) - t1;
        b = sra(sra(d * d, 12) * t3, 14);
        fine = a + b;
        r.temp = sra(fine * 32'd5 + 32'd128, 8);

        // pressure
        a = sra(fine, 1) - 32'd64000;
        q = sra(a, 2);
        b = sra(q * q, 11) * p6;
        b = b + ((a * p5) << 1);
        b = sra(b, 2) + (p4 << 16);
        a = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * a, 1), 18);
        a = sra((32'd32768 + a) * p1, 15);
        if (a == 32'd0)
            r.press = 32'd0;
        else
        begin
            pq = ((32'd1048576 - 32'(rp)) - sra(b, 12)) * 32'd3125;
            if (pq < 32'h8000_0000)
                pq = (pq << 1) / a;
            else
                pq = (pq / a) * 32'd2;
            q = pq >> 3;
            a = sra(p9 * ((q * q) >> 13), 12);
            b = sra((pq >> 2) * p8, 13);
            r.press = pq + sra(a + b + p7, 4);
        end

        // humidity with clamp
        d = fine - 32'd76800;
        a = sra(((32'(rh) << 14) - (h4 << 20) - (h5 * d)) + 32'd16384, 15);
        b = sra(sra(d * h6, 10) * (sra(d * h3, 11) + 32'd32768), 10) + 32'd2097152;
        b = sra(b * h2 + 32'd8192, 14);
        hv = a * b;
        q = sra(hv, 15);
        hv = hv - sra(sra(q * q, 7) * h1, 4);
        if (hv[31])
            hv = 32'd0;
        if (hv > 32'd419430400)
            hv = 32'd419430400;
        r.hum = 17'(hv >> 12);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task automatic apb_write(reg_idx_t idx, logic [63:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx) << 3;
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_TEMP:    cal_temp = val[47:0];
            REG_PRESS_A: cal_pa   = val[47:0];
            REG_PRESS_B: cal_pb   = val[47:0];
            REG_PRESS_C: cal_pc   = val[47:0];
            REG_HUM_A:   cal_ha   = val[31:0];
            REG_HUM_B:   cal_hb   = val[39:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Send one reading beat; the sender may idle first. Valid stays up after
    // the beat so the next one can follow at once; drain drops it.
    task automatic send_reading(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        raw_temp  <= rt;
        raw_press <= rp;
        raw_hum   <= rh;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        compensated_q.push_back(compensate(rt, rp, rh));
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (compensated_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // Typical factory calibration
    task automatic load_typical();
        apb_write(REG_TEMP,    64'({16'd50, 16'd26000, 16'd28000}));
        apb_write(REG_PRESS_A, 64'({16'hF3A0, 16'hD600, 16'd36000}));
        apb_write(REG_PRESS_B, 64'({16'hFFF9, 16'd120, 16'd6500}));
        apb_write(REG_PRESS_C, 64'({16'd4300, 16'hEE00, 16'd15}));
        apb_write(REG_HUM_A,   64'({8'd0, 16'd360, 8'd75}));
        apb_write(REG_HUM_B,   64'({8'd30, 16'd50, 16'd320}));
    endtask

    task automatic test_zero_coeffs();
        send_reading(20'd0, 20'd0, 16'd0);
        send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_reading(20'd524288, 20'd400000, 16'd30000);
        drain();
    endtask

    task automatic test_directed();
        load_typical();
        send_reading(20'd0, 20'd0, 16'd0);
        send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_reading(20'd519888, 20'd415148, 16'd28000);
        send_reading(20'd519888, 20'd0, 16'hFFFF);
        send_reading(20'd0, 20'hFFFFF, 16'd0);
        send_reading(20'h80000, 20'h80000, 16'h8000);
        drain();
        // extremes of every coefficient field
        apb_write(REG_TEMP,    64'h0000_FFFF_FFFF_FFFF);
        apb_write(REG_PRESS_A, 64'h0000_8000_8000_FFFF);
        apb_write(REG_PRESS_B, 64'h0000_7FFF_7FFF_7FFF);
        apb_write(REG_PRESS_C, 64'h0000_8000_8000_8000);
        apb_write(REG_HUM_A,   64'h0000_0000_FF80_00FF);
        apb_write(REG_HUM_B,   64'h0000_007F_7FFF_8000);
        send_reading(20'd0, 20'd0, 16'd0);
        send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_reading(20'h55555, 20'hAAAAA, 16'h5555);
        send_reading(20'hAAAAA, 20'h55555, 16'hAAAA);
        drain();
        // zero pressure divisor: p1 of zero
        load_typical();
        apb_write(REG_PRESS_A, 64'({16'hF3A0, 16'hD600, 16'd0}));
        send_reading(20'd519888, 20'd415148, 16'd28000);
        send_reading(20'hFFFFF, 20'h0, 16'hFFFF);
        drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
            begin
                drain();
                if ($urandom_range(1))
                    load_typical();
                apb_write(REG_TEMP,    {$urandom(), $urandom()});
                apb_write(REG_PRESS_A, {$urandom(), $urandom()});
                apb_write(REG_PRESS_B, {$urandom(), $urandom()});
                apb_write(REG_PRESS_C, {$urandom(), $urandom()});
                apb_write(REG_HUM_A,   {$urandom(), $urandom()});
                apb_write(REG_HUM_B,   {$urandom(), $urandom()});
                if ($urandom_range(1))
                    load_typical();
            end
            send_reading(20'($urandom()), 20'($urandom()), 16'($urandom()));
        end
        drain();
    endtask

    // Result checker and receiver stall
    initial
    begin
        reading_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (compensated_q.size() == 0)
                begin
                    report_mismatch("result beat with nothing pending", temp_centi, 32'd0);
                end
                else
                begin
                    want = compensated_q.pop_front();
                    if (temp_centi !== want.temp)
                        report_mismatch("temp_centi", temp_centi, want.temp);
                    if (press_pa !== want.press)
                        report_mismatch("press_pa", press_pa, want.press);
                    if (hum_q10 !== want.hum)
                        report_mismatch("hum_q10", 32'(hum_q10), 32'(want.hum));
                end
            end
            @(negedge clk);
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog on cycles without any beat
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCH_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        errors = 0;
        send_idle_pct = 34;
        recv_idle_pct = 72;
        rst_n = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0; in_valid = 1'b0; out_stall = 1'b0;
        raw_temp = '0; raw_press = '0; raw_hum = '0;
        cal_temp = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0; cal_ha = '0; cal_hb = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_zero_coeffs();
        test_directed();
        test_random(270);
        send_idle_pct = 72;
        recv_idle_pct = 34;
        test_random(270);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(260);

        if (errors == 0 && compensated_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
